[design/c2s_pkg.sv]
package c2s_pkg;

    localparam int CORDIC_STAGES = 28;
    localparam int ROOT_BITS     = 32;
    localparam int IN_W          = 32;
    localparam int VEC_W         = 64;
    localparam int ANG_W         = 32;
    localparam int FRAC_BITS     = 26;
    localparam int GAIN_W        = 28;
    localparam int LON_W         = 31;
    localparam int LAT_W         = 30;

    localparam logic signed [ANG_W-1:0]  ANG_PI      = 32'sd843314857;
    localparam logic signed [ANG_W-1:0]  ANG_HALF_PI = 32'sd421657428;
    localparam logic signed [GAIN_W-1:0] GAIN_Q26    = 28'sd110512210;

    typedef struct packed {
        logic zero_vec;
        logic xy_zero;
    } c2s_flags_t;

    // aux carries z*K through the longitude pass, then the longitude angle
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] ang;
        logic signed [VEC_W-1:0] aux;
        c2s_flags_t              flags;
    } c2s_cword_t;

    // atan(2^-i) in Q.28, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 32'sd210828714;
            5'd1:    val = 32'sd124459457;
            5'd2:    val = 32'sd65760959;
            5'd3:    val = 32'sd33381290;
            5'd4:    val = 32'sd16755422;
            5'd5:    val = 32'sd8385879;
            5'd6:    val = 32'sd4193963;
            5'd7:    val = 32'sd2097109;
            5'd8:    val = 32'sd1048571;
            5'd9:    val = 32'sd524287;
            5'd10:   val = 32'sd262144;
            5'd11:   val = 32'sd131072;
            5'd12:   val = 32'sd65536;
            5'd13:   val = 32'sd32768;
            5'd14:   val = 32'sd16384;
            5'd15:   val = 32'sd8192;
            5'd16:   val = 32'sd4096;
            5'd17:   val = 32'sd2048;
            5'd18:   val = 32'sd1024;
            5'd19:   val = 32'sd512;
            5'd20:   val = 32'sd256;
            5'd21:   val = 32'sd128;
            5'd22:   val = 32'sd64;
            5'd23:   val = 32'sd32;
            5'd24:   val = 32'sd16;
            5'd25:   val = 32'sd8;
            5'd26:   val = 32'sd4;
            5'd27:   val = 32'sd2;
            5'd28:   val = 32'sd1;
            5'd29:   val = 32'sd0;
            5'd30:   val = 32'sd0;
            5'd31:   val = 32'sd0;
            default: val = 32'sd0;
        endcase
        return val;
    endfunction

endpackage

[design/c2s_front.sv]
module c2s_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 vector_valid,
    input  logic signed [c2s_pkg::IN_W-1:0]      x_component,
    input  logic signed [c2s_pkg::IN_W-1:0]      y_component,
    input  logic signed [c2s_pkg::IN_W-1:0]      z_component,
    output logic        [c2s_pkg::VEC_W-1:0]     sq_x,
    output logic        [c2s_pkg::VEC_W-1:0]     sq_y,
    output logic        [c2s_pkg::VEC_W-1:0]     sq_z,
    output c2s_pkg::c2s_cword_t                  word,
    output logic                                 word_valid
);

    localparam int PROD_W = c2s_pkg::IN_W + c2s_pkg::GAIN_W;
    localparam int EXT_W  = c2s_pkg::VEC_W - c2s_pkg::IN_W - c2s_pkg::FRAC_BITS;
    localparam int ZX_W   = c2s_pkg::VEC_W - c2s_pkg::IN_W;

    logic signed [c2s_pkg::IN_W-1:0] x0_reg;
    logic signed [c2s_pkg::IN_W-1:0] y0_reg;
    logic signed [c2s_pkg::IN_W-1:0] z0_reg;
    logic                            v0_reg;

    logic [c2s_pkg::IN_W-1:0]  ax;
    logic [c2s_pkg::IN_W-1:0]  ay;
    logic [c2s_pkg::IN_W-1:0]  az;
    logic [c2s_pkg::VEC_W-1:0] sq_x_next;
    logic [c2s_pkg::VEC_W-1:0] sq_y_next;
    logic [c2s_pkg::VEC_W-1:0] sq_z_next;
    logic [c2s_pkg::VEC_W-1:0] sq_x_reg;
    logic [c2s_pkg::VEC_W-1:0] sq_y_reg;
    logic [c2s_pkg::VEC_W-1:0] sq_z_reg;

    logic signed [PROD_W-1:0]        zprod;
    logic signed [c2s_pkg::VEC_W-1:0] vx;
    logic signed [c2s_pkg::VEC_W-1:0] vy;
    c2s_pkg::c2s_cword_t             word_next;
    c2s_pkg::c2s_cword_t             word_reg;
    logic                            word_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg         <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg         <= vector_valid;
            word_valid_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg   <= x_component;
            y0_reg   <= y_component;
            z0_reg   <= z_component;
            sq_x_reg <= sq_x_next;
            sq_y_reg <= sq_y_next;
            sq_z_reg <= sq_z_next;
            word_reg <= word_next;
        end
    end

    assign ax = x0_reg[c2s_pkg::IN_W-1] ? (~x0_reg + {{(c2s_pkg::IN_W-1){1'b0}}, 1'b1}) : x0_reg;
    assign ay = y0_reg[c2s_pkg::IN_W-1] ? (~y0_reg + {{(c2s_pkg::IN_W-1){1'b0}}, 1'b1}) : y0_reg;
    assign az = z0_reg[c2s_pkg::IN_W-1] ? (~z0_reg + {{(c2s_pkg::IN_W-1){1'b0}}, 1'b1}) : z0_reg;

    assign sq_x_next = {{ZX_W{1'b0}}, ax} * {{ZX_W{1'b0}}, ax};
    assign sq_y_next = {{ZX_W{1'b0}}, ay} * {{ZX_W{1'b0}}, ay};
    assign sq_z_next = {{ZX_W{1'b0}}, az} * {{ZX_W{1'b0}}, az};

    assign zprod = PROD_W'(z0_reg) * PROD_W'(c2s_pkg::GAIN_Q26);

    assign vx = {{EXT_W{x0_reg[c2s_pkg::IN_W-1]}}, x0_reg, {c2s_pkg::FRAC_BITS{1'b0}}};
    assign vy = {{EXT_W{y0_reg[c2s_pkg::IN_W-1]}}, y0_reg, {c2s_pkg::FRAC_BITS{1'b0}}};

    // left half-plane: quarter turn onto the right half-plane first
    always_comb
    begin
        word_next.x   = vx;
        word_next.y   = vy;
        word_next.ang = '0;
        if (x0_reg[c2s_pkg::IN_W-1])
        begin
            if (!y0_reg[c2s_pkg::IN_W-1])
            begin
                word_next.x   = vy;
                word_next.y   = -vx;
                word_next.ang = c2s_pkg::ANG_HALF_PI;
            end
            else
            begin
                word_next.x   = -vy;
                word_next.y   = vx;
                word_next.ang = -c2s_pkg::ANG_HALF_PI;
            end
        end
        word_next.aux            = {{(c2s_pkg::VEC_W-PROD_W){zprod[PROD_W-1]}}, zprod};
        word_next.flags.xy_zero  = (x0_reg == '0) && (y0_reg == '0);
        word_next.flags.zero_vec = (x0_reg == '0) && (y0_reg == '0) && (z0_reg == '0);
    end

    assign sq_x       = sq_x_reg;
    assign sq_y       = sq_y_reg;
    assign sq_z       = sq_z_reg;
    assign word       = word_reg;
    assign word_valid = word_valid_reg;

endmodule

[design/c2s_isqrt.sv]
module c2s_isqrt (
    input  logic                                clk,
    input  logic                                en,
    input  logic [c2s_pkg::VEC_W-1:0]           sq_x,
    input  logic [c2s_pkg::VEC_W-1:0]           sq_y,
    input  logic [c2s_pkg::VEC_W-1:0]           sq_z,
    output logic [c2s_pkg::ROOT_BITS-1:0]       root
);

    localparam int NB  = c2s_pkg::ROOT_BITS;
    localparam int DLY = 2 * c2s_pkg::CORDIC_STAGES - NB;

    logic [c2s_pkg::VEC_W-1:0] rem_reg  [0:NB];
    logic [NB-1:0]             root_reg [1:NB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= sq_x + sq_y + sq_z;
        end
    end

    // one root bit per stage, most significant first
    for (genvar j = 0; j < NB; j++)
    begin : g_bit
        localparam int K = NB - 1 - j;

        logic [NB-1:0]             root_src;
        logic [c2s_pkg::VEC_W-1:0] trial;
        logic                      take;
        logic [c2s_pkg::VEC_W-1:0] rem_next;
        logic [NB-1:0]             root_next;

        if (j == 0)
        begin : g_first
            assign root_src = '0;
        end
        else
        begin : g_rest
            assign root_src = root_reg[j];
        end

        assign trial = ({{(c2s_pkg::VEC_W-NB){1'b0}}, root_src} << (K + 1))
                     + ({{(c2s_pkg::VEC_W-1){1'b0}}, 1'b1} << (2 * K));
        assign take      = rem_reg[j] >= trial;
        assign rem_next  = take ? (rem_reg[j] - trial) : rem_reg[j];
        assign root_next = take ? (root_src | ({{(NB-1){1'b0}}, 1'b1} << K)) : root_src;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= rem_next;
                root_reg[j+1] <= root_next;
            end
        end
    end

    // line up with the two CORDIC passes
    if (DLY > 0)
    begin : g_delay
        logic [NB-1:0] len_reg [1:DLY];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[1] <= root_reg[NB];
            end
        end

        for (genvar d = 1; d < DLY; d++)
        begin : g_tap
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    len_reg[d+1] <= len_reg[d];
                end
            end
        end

        assign root = len_reg[DLY];
    end
    else
    begin : g_nodelay
        assign root = root_reg[NB];
    end

endmodule

[design/c2s_cordic.sv]
module c2s_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  c2s_pkg::c2s_cword_t                  word,
    input  logic                                 word_valid,
    output logic signed [c2s_pkg::LON_W-1:0]     longitude,
    output logic signed [c2s_pkg::LAT_W-1:0]     latitude,
    output logic                                 out_valid
);

    localparam int N     = c2s_pkg::CORDIC_STAGES;
    localparam int STEPS = 2 * N;

    c2s_pkg::c2s_cword_t stg_reg [1:STEPS];
    logic                vld_reg [1:STEPS];

    // stages 0..N-1: longitude pass; N..2N-1: latitude pass
    for (genvar i = 0; i < STEPS; i++)
    begin : g_stage
        localparam int SH = (i < N) ? i : i - N;

        c2s_pkg::c2s_cword_t              src;
        c2s_pkg::c2s_cword_t              stage_next;
        logic                             vld_src;
        logic signed [c2s_pkg::VEC_W-1:0] cx;
        logic signed [c2s_pkg::VEC_W-1:0] cy;
        logic signed [c2s_pkg::VEC_W-1:0] dx;
        logic signed [c2s_pkg::VEC_W-1:0] dy;
        logic signed [c2s_pkg::ANG_W-1:0] step_ang;

        if (i == 0)
        begin : g_entry
            assign src     = word;
            assign vld_src = word_valid;
        end
        else if (i == N)
        begin : g_swap
            assign src.x     = stg_reg[i].x;
            assign src.y     = stg_reg[i].aux;
            assign src.ang   = '0;
            assign src.aux   = {{(c2s_pkg::VEC_W-c2s_pkg::ANG_W){stg_reg[i].ang[c2s_pkg::ANG_W-1]}},
                                stg_reg[i].ang};
            assign src.flags = stg_reg[i].flags;
            assign vld_src   = vld_reg[i];
        end
        else
        begin : g_mid
            assign src     = stg_reg[i];
            assign vld_src = vld_reg[i];
        end

        assign cx       = src.x;
        assign cy       = src.y;
        assign dx       = cy >>> SH;
        assign dy       = cx >>> SH;
        assign step_ang = c2s_pkg::atan_q28(5'(SH));

        always_comb
        begin
            stage_next = src;
            if (!cy[c2s_pkg::VEC_W-1])
            begin
                stage_next.x   = cx + dx;
                stage_next.y   = cy - dy;
                stage_next.ang = src.ang + step_ang;
            end
            else
            begin
                stage_next.x   = cx - dx;
                stage_next.y   = cy + dy;
                stage_next.ang = src.ang - step_ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[i+1] <= stage_next;
            end
        end
    end

    logic signed [c2s_pkg::ANG_W-1:0] lon_raw;
    logic signed [c2s_pkg::ANG_W-1:0] lat_raw;
    logic signed [c2s_pkg::ANG_W-1:0] lon_next;
    logic signed [c2s_pkg::ANG_W-1:0] lat_next;
    logic signed [c2s_pkg::LON_W-1:0] lon_reg;
    logic signed [c2s_pkg::LAT_W-1:0] lat_reg;
    logic                             out_valid_reg;

    assign lon_raw = stg_reg[STEPS].aux[c2s_pkg::ANG_W-1:0];
    assign lat_raw = stg_reg[STEPS].ang;

    always_comb
    begin
        if (stg_reg[STEPS].flags.xy_zero)
            lon_next = '0;
        else if (lon_raw > c2s_pkg::ANG_PI)
            lon_next = c2s_pkg::ANG_PI;
        else if (lon_raw < -c2s_pkg::ANG_PI)
            lon_next = -c2s_pkg::ANG_PI;
        else
            lon_next = lon_raw;

        if (stg_reg[STEPS].flags.zero_vec)
            lat_next = '0;
        else if (lat_raw > c2s_pkg::ANG_HALF_PI)
            lat_next = c2s_pkg::ANG_HALF_PI;
        else if (lat_raw < -c2s_pkg::ANG_HALF_PI)
            lat_next = -c2s_pkg::ANG_HALF_PI;
        else
            lat_next = lat_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lon_reg <= lon_next[c2s_pkg::LON_W-1:0];
            lat_reg <= lat_next[c2s_pkg::LAT_W-1:0];
        end
    end

    assign longitude = lon_reg;
    assign latitude  = lat_reg;
    assign out_valid = out_valid_reg;

endmodule

[design/cartesian_to_spherical.sv]
// Throughput: one request per cycle while the pipeline is not frozen, through the chain of
// CORDIC micro-rotation stages that runs the longitude pass and then the latitude pass,
// beside a one-bit-a-stage root.
// result_stall freezes the whole pipeline while a result is held; vector_stall follows it.
// Reset (rst_n, asynchronous, active low) clears the valid bits only.
module cartesian_to_spherical (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vector_valid,
    output logic                                 vector_stall,
    input  logic signed [c2s_pkg::IN_W-1:0]      x_component,
    input  logic signed [c2s_pkg::IN_W-1:0]      y_component,
    input  logic signed [c2s_pkg::IN_W-1:0]      z_component,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic        [c2s_pkg::ROOT_BITS-1:0] vector_length,
    output logic signed [c2s_pkg::LON_W-1:0]     longitude,
    output logic signed [c2s_pkg::LAT_W-1:0]     latitude
);

    logic                          en;
    logic [c2s_pkg::VEC_W-1:0]     sq_x;
    logic [c2s_pkg::VEC_W-1:0]     sq_y;
    logic [c2s_pkg::VEC_W-1:0]     sq_z;
    c2s_pkg::c2s_cword_t           word;
    logic                          word_valid;

    assign vector_stall = result_valid & result_stall;
    assign en           = ~vector_stall;

    c2s_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .vector_valid (vector_valid),
        .x_component  (x_component),
        .y_component  (y_component),
        .z_component  (z_component),
        .sq_x         (sq_x),
        .sq_y         (sq_y),
        .sq_z         (sq_z),
        .word         (word),
        .word_valid   (word_valid)
    );

    c2s_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .sq_x (sq_x),
        .sq_y (sq_y),
        .sq_z (sq_z),
        .root (vector_length)
    );

    c2s_cordic u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .word       (word),
        .word_valid (word_valid),
        .longitude  (longitude),
        .latitude   (latitude),
        .out_valid  (result_valid)
    );

endmodule

[tb/c2s_result_check.sv]
`timescale 1ns / 100ps
module c2s_result_check (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vector_valid,
    input  logic                                 vector_stall,
    input  logic signed [c2s_pkg::IN_W-1:0]      x_component,
    input  logic signed [c2s_pkg::IN_W-1:0]      y_component,
    input  logic signed [c2s_pkg::IN_W-1:0]      z_component,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  logic        [c2s_pkg::ROOT_BITS-1:0] vector_length,
    input  logic signed [c2s_pkg::LON_W-1:0]     longitude,
    input  logic signed [c2s_pkg::LAT_W-1:0]     latitude,
    output int                                   fail_count,
    output int                                   outstanding,
    output int                                   answered
);

    localparam longint LON_LIMIT = 843314857;
    localparam longint LAT_LIMIT = 421657428;
    localparam longint GAIN_Q26  = 110512210;
    localparam longint UNIT_Q26  = 67108864;

    typedef struct packed {
        logic        [c2s_pkg::ROOT_BITS-1:0] len;
        logic signed [c2s_pkg::LON_W-1:0]     lon;
        logic signed [c2s_pkg::LAT_W-1:0]     lat;
    } spherical_t;

    spherical_t spherical_q[$];
    longint     atan_step [0:31];

    initial
    begin
        atan_step = '{
            210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
            4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
            16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2,
            1, 0, 0, 0
        };
    end

    // vectoring pass: drives y to zero, returns the swept angle
    function automatic longint rotate_to_axis(input longint xv, input longint yv,
                                              input longint ang, output longint x_end);
        longint dx;
        longint dy;
        for (int i = 0; i < c2s_pkg::CORDIC_STAGES && i < 32; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv  = xv + dx;
                yv  = yv - dy;
                ang = ang + atan_step[i];
            end
            else
            begin
                xv  = xv - dx;
                yv  = yv + dy;
                ang = ang - atan_step[i];
            end
        end
        x_end = xv;
        return ang;
    endfunction

    function automatic spherical_t to_spherical(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] z);
        longint          sx, sy, sz, vx, vy, ang0, x1, x2, lon, lat;
        longint unsigned ax, ay, az, sumsq;
        logic [31:0]     root, trial;
        spherical_t      r;
        sx = x;
        sy = y;
        sz = z;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        sumsq = ax * ax + ay * ay + az * az;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= sumsq)
                root = trial;
        end
        lon = 0;
        lat = 0;
        if (sx != 0 || sy != 0 || sz != 0)
        begin
            vx   = sx * UNIT_Q26;
            vy   = sy * UNIT_Q26;
            ang0 = 0;
            // left half-plane: pre-rotate by a quarter turn
            if (sx < 0)
            begin
                if (sy >= 0)
                begin
                    vx   = sy * UNIT_Q26;
                    vy   = -sx * UNIT_Q26;
                    ang0 = LAT_LIMIT;
                end
                else
                begin
                    vx   = -sy * UNIT_Q26;
                    vy   = sx * UNIT_Q26;
                    ang0 = -LAT_LIMIT;
                end
            end
            lon = rotate_to_axis(vx, vy, ang0, x1);
            if (sx == 0 && sy == 0)
                lon = 0;
            if (lon > LON_LIMIT)
                lon = LON_LIMIT;
            else if (lon < -LON_LIMIT)
                lon = -LON_LIMIT;
            lat = rotate_to_axis(x1, sz * GAIN_Q26, 0, x2);
            if (lat > LAT_LIMIT)
                lat = LAT_LIMIT;
            else if (lat < -LAT_LIMIT)
                lat = -LAT_LIMIT;
        end
        r.len = root;
        r.lon = lon[c2s_pkg::LON_W-1:0];
        r.lat = lat[c2s_pkg::LAT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch, result %0d at %0t: %s", answered, $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        spherical_t want;
        if (rst_n)
        begin
            if (vector_valid && !vector_stall)
                spherical_q.push_back(to_spherical(x_component, y_component, z_component));
            if (result_valid && !result_stall)
            begin
                if (spherical_q.size() == 0)
                    report_mismatch("result with no request waiting");
                else
                begin
                    want = spherical_q.pop_front();
                    if (vector_length !== want.len)
                        report_mismatch($sformatf("vector_length expected %0d got %0d",
                                                  want.len, vector_length));
                    if (longitude !== want.lon)
                        report_mismatch($sformatf("longitude expected %0d got %0d",
                                                  want.lon, longitude));
                    if (latitude !== want.lat)
                        report_mismatch($sformatf("latitude expected %0d got %0d",
                                                  want.lat, latitude));
                end
                answered++;
            end
        end
        outstanding = spherical_q.size();
    end

endmodule

[tb/cartesian_to_spherical_test.sv]
`timescale 1ns / 100ps
module cartesian_to_spherical_test;

    localparam int PIPE_CYCLES     = 2 * c2s_pkg::CORDIC_STAGES + 3;
    localparam int RANDOM_REQUESTS = 800;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AT_RESULT  = 120;

    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 vector_valid = 1'b0;
    logic                                 vector_stall;
    logic signed [c2s_pkg::IN_W-1:0]      x_component  = '0;
    logic signed [c2s_pkg::IN_W-1:0]      y_component  = '0;
    logic signed [c2s_pkg::IN_W-1:0]      z_component  = '0;
    logic                                 result_valid;
    logic                                 result_stall = 1'b0;
    logic        [c2s_pkg::ROOT_BITS-1:0] vector_length;
    logic signed [c2s_pkg::LON_W-1:0]     longitude;
    logic signed [c2s_pkg::LAT_W-1:0]     latitude;

    int   fail_count;
    int   outstanding;
    int   answered;
    int   sent         = 0;
    int   directed     = 0;
    logic choking      = 1'b0;

    cartesian_to_spherical uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vector_valid (vector_valid),
        .vector_stall (vector_stall),
        .x_component  (x_component),
        .y_component  (y_component),
        .z_component  (z_component),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .vector_length(vector_length),
        .longitude    (longitude),
        .latitude     (latitude)
    );

    c2s_result_check result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .vector_valid (vector_valid),
        .vector_stall (vector_stall),
        .x_component  (x_component),
        .y_component  (y_component),
        .z_component  (z_component),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .vector_length(vector_length),
        .longitude    (longitude),
        .latitude     (latitude),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .answered     (answered)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("timed out with %0d requests outstanding", outstanding);
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [31:0] pick_component();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5:       v = $signed($urandom_range(0, 64)) - 32;
            6:          v = $urandom_range(0, 1) ? MAXV : MINV;
            7:          v = '0;
            8:          v = $signed($urandom) >>> $urandom_range(0, 31);
            default:    v = $urandom_range(0, 1) ? (32'sd1 <<< $urandom_range(0, 30))
                                                 : -(32'sd1 <<< $urandom_range(0, 31));
        endcase
        return v;
    endfunction

    task automatic offer_vector(input logic signed [31:0] x,
                                input logic signed [31:0] y,
                                input logic signed [31:0] z);
        int gap;
        gap = (choking || (sent / 60) % 4 == 1) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            vector_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vector_valid <= 1'b1;
        x_component  <= x;
        y_component  <= y;
        z_component  <= z;
        do
            @(posedge clk);
        while (vector_stall);
        sent++;
    endtask

    // output side: random stalls, one long hold-off to back up the pipe
    initial
    begin : drain
        int wait_cycles;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == HOLD_AT_RESULT)
            begin
                choking      <= 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
                choking      <= 1'b0;
            end
            else
            begin
                wait_cycles = ((taken / 50) % 4 == 3) ? 0 : $urandom_range(0, 6);
                if (wait_cycles > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
            do
                @(posedge clk);
            while (!result_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int guard;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        offer_vector(0, 0, 0);
        offer_vector(1, 0, 0);
        offer_vector(0, 1, 0);
        offer_vector(0, -1, 0);
        offer_vector(-1, 0, 0);
        offer_vector(-1, -1, 0);
        offer_vector(-1, 1, 0);
        offer_vector(1, -1, 0);
        offer_vector(0, 0, 1);
        offer_vector(0, 0, -1);
        offer_vector(0, 0, MAXV);
        offer_vector(0, 0, MINV);
        offer_vector(MAXV, 0, 0);
        offer_vector(MINV, 0, 0);
        offer_vector(0, MAXV, 0);
        offer_vector(0, MINV, 0);
        offer_vector(MINV, MINV, MINV);
        offer_vector(MAXV, MAXV, MAXV);
        offer_vector(MINV, MAXV, MINV);
        offer_vector(MAXV, MINV, MAXV);
        offer_vector(MINV, -1, 0);
        offer_vector(MINV, 0, MAXV);
        offer_vector(3, 4, 12);
        offer_vector(-7, -24, -1);
        directed = sent;

        repeat (RANDOM_REQUESTS)
            offer_vector(pick_component(), pick_component(), pick_component());
        vector_valid <= 1'b0;

        guard = 0;
        do
        begin
            @(negedge clk);
            guard++;
        end
        while (outstanding != 0 && guard < 20000);
        repeat (PIPE_CYCLES + 20) @(posedge clk);

        if (outstanding != 0)
            $display("%0d requests never answered", outstanding);
        $display("%0d requests (%0d directed, %0d random), %0d results compared",
                 sent, directed, sent - directed, answered);
        $display("random stalls on both sides plus a %0d-cycle output hold-off", HOLD_CYCLES);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
